>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is held
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/icl_pkg.sv
`default_nettype none

package icl_pkg;

  // Fixed field widths
  localparam int VALUE_W           = 33;
  localparam int OPND_IN_W         = 16;
  localparam int OPERAND_WIDTH_DEF = 16;

  // Operation codes; 6 and 7 are invalid
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_LCM = 3'd4,
    OP_GCD = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DIV_ZERO = 2'd1,
    STAT_ZERO_OPND = 2'd2,
    STAT_INVALID  = 2'd3
  } status_t;

  // Input item
  typedef struct packed {
    logic [2:0]           operation;
    logic [OPND_IN_W-1:0] first_operand;
    logic [OPND_IN_W-1:0] second_operand;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GCD,
    S_LCM_INIT,
    S_DIV,
    S_DIV_END,
    S_DONE
  } ctl_state_t;

  // Datapath commands
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ADD,
    DP_SUB,
    DP_MUL,
    DP_CLEAR,
    DP_GCD_STEP,
    DP_GCD_FIX,
    DP_DIV_INIT_B,
    DP_DIV_INIT_G,
    DP_DIV_STEP,
    DP_QUO,
    DP_LCM_MUL
  } dp_cmd_t;

  // Controller to datapath
  typedef struct packed {
    dp_cmd_t cmd;
  } dp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic gcd_eq;
    logic div_last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/icl_dpath.sv
`default_nettype none

module icl_dpath #(
  parameter int OPERAND_WIDTH = icl_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire icl_pkg::dp_ctl_t               ctl,
  input  wire logic [icl_pkg::OPND_IN_W-1:0]  in_a,
  input  wire logic [icl_pkg::OPND_IN_W-1:0]  in_b,
  output icl_pkg::dp_stat_t                   stat,
  output logic [icl_pkg::VALUE_W-1:0]         value
);
  import icl_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int KW = $clog2(W);
  localparam int CW = $clog2(W);
  localparam int PW = 2 * W + VALUE_W;

  // Operands as taken in
  logic [W-1:0]       opa_r, opb_r;
  // Binary GCD working pair and common power of two
  logic [W-1:0]       ga_r, gb_r;
  logic [KW-1:0]      k_r;
  // Restoring divider
  logic [W-1:0]       q_r, rem_r, dv_r;
  logic [CW-1:0]      cnt_r;
  // Result
  logic [VALUE_W-1:0] res_r;

  logic [W:0]         div_t;
  logic [W:0]         div_d;
  logic               div_ge;
  logic [W-1:0]       g_diff_ab, g_diff_ba;
  logic [W-1:0]       mul_x;
  logic [2*W-1:0]     prod;
  logic [PW-1:0]      prod_ext;

  // Divider step: shift next dividend bit into partial remainder, trial subtract
  assign div_t  = {rem_r, q_r[W-1]};
  assign div_d  = div_t - {1'b0, dv_r};
  assign div_ge = div_t >= {1'b0, dv_r};

  assign g_diff_ab = ga_r - gb_r;
  assign g_diff_ba = gb_r - ga_r;

  // One shared multiplier: a*b, or quotient*b for lcm
  assign mul_x    = (ctl.cmd == DP_LCM_MUL) ? q_r : opa_r;
  assign prod     = mul_x * opb_r;
  assign prod_ext = PW'(prod);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      DP_LOAD: begin
        opa_r <= W'(in_a);
        opb_r <= W'(in_b);
        ga_r  <= W'(in_a);
        gb_r  <= W'(in_b);
        k_r   <= '0;
      end
      DP_ADD:   res_r <= VALUE_W'(opa_r) + VALUE_W'(opb_r);
      DP_SUB:   res_r <= VALUE_W'(opa_r) - VALUE_W'(opb_r);
      DP_MUL:   res_r <= prod_ext[VALUE_W-1:0];
      DP_CLEAR: res_r <= '0;
      DP_GCD_STEP: begin
        priority if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          k_r  <= k_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (ga_r >= gb_r) begin
          ga_r <= g_diff_ab >> 1;
        end else begin
          gb_r <= g_diff_ba >> 1;
        end
      end
      DP_GCD_FIX: begin
        ga_r  <= ga_r << k_r;
        res_r <= VALUE_W'(ga_r << k_r);
      end
      DP_DIV_INIT_B, DP_DIV_INIT_G: begin
        q_r   <= opa_r;
        rem_r <= '0;
        dv_r  <= (ctl.cmd == DP_DIV_INIT_G) ? ga_r : opb_r;
        cnt_r <= CW'(W - 1);
      end
      DP_DIV_STEP: begin
        q_r   <= {q_r[W-2:0], div_ge};
        rem_r <= div_ge ? div_d[W-1:0] : div_t[W-1:0];
        cnt_r <= cnt_r - 1'b1;
      end
      DP_QUO:     res_r <= VALUE_W'(q_r);
      DP_LCM_MUL: res_r <= prod_ext[VALUE_W-1:0];
      default: ;
    endcase
  end

  // Status to controller
  assign stat.a_zero   = (opa_r == '0);
  assign stat.b_zero   = (opb_r == '0);
  assign stat.gcd_eq   = (ga_r == gb_r);
  assign stat.div_last = (cnt_r == '0);

  assign value = res_r;

endmodule

`default_nettype wire

>>> hw/rtl/icl_ctrl.sv
`default_nettype none

module icl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [2:0]        in_op,
  input  wire icl_pkg::dp_stat_t stat,
  output icl_pkg::dp_ctl_t       ctl,
  output logic                   busy,
  output logic                   done,
  output logic [1:0]             status
);
  import icl_pkg::*;

  ctl_state_t state_r, state_nxt;
  op_t        op_r, op_nxt;
  status_t    status_r, status_nxt;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      op_r     <= OP_ADD;
      status_r <= STAT_OK;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      status_r <= status_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_DECODE;
          op_nxt     = op_t'(in_op);
          status_nxt = STAT_OK;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (op_r)
          OP_ADD, OP_SUB, OP_MUL: ;
          OP_DIV: begin
            if (stat.b_zero) status_nxt = STAT_DIV_ZERO;
            else state_nxt = S_DIV;
          end
          OP_LCM, OP_GCD: begin
            if (stat.a_zero || stat.b_zero) status_nxt = STAT_ZERO_OPND;
            else state_nxt = S_GCD;
          end
          default: status_nxt = STAT_INVALID;
        endcase
      end
      S_GCD: begin
        if (stat.gcd_eq) state_nxt = (op_r == OP_GCD) ? S_DONE : S_LCM_INIT;
      end
      S_LCM_INIT: state_nxt = S_DIV;
      S_DIV: begin
        if (stat.div_last) state_nxt = S_DIV_END;
      end
      S_DIV_END: state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctl.cmd = DP_NOP;
    unique case (state_r)
      S_IDLE: if (start) ctl.cmd = DP_LOAD;
      S_DECODE: begin
        unique case (op_r)
          OP_ADD: ctl.cmd = DP_ADD;
          OP_SUB: ctl.cmd = DP_SUB;
          OP_MUL: ctl.cmd = DP_MUL;
          OP_DIV: ctl.cmd = stat.b_zero ? DP_CLEAR : DP_DIV_INIT_B;
          OP_LCM, OP_GCD: ctl.cmd = (stat.a_zero || stat.b_zero) ? DP_CLEAR : DP_NOP;
          default: ctl.cmd = DP_CLEAR;
        endcase
      end
      S_GCD:      ctl.cmd = stat.gcd_eq ? DP_GCD_FIX : DP_GCD_STEP;
      S_LCM_INIT: ctl.cmd = DP_DIV_INIT_G;
      S_DIV:      ctl.cmd = DP_DIV_STEP;
      S_DIV_END:  ctl.cmd = (op_r == OP_DIV) ? DP_QUO : DP_LCM_MUL;
      S_DONE:     ctl.cmd = DP_NOP;
      default:    ctl.cmd = DP_NOP;
    endcase
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign status = status_r;

endmodule

`default_nettype wire

>>> hw/rtl/integer_calculator_lcm_gcd.sv
// Add, sub, mul and every error status go from decode straight to done; divide runs
// the restoring divider; gcd runs binary GCD steps until the pair is equal; lcm runs
// the GCD, then divides the first operand by it and multiplies by the second.
// The divider retires one bit a cycle.
// Throughput: one item in flight; a new item is taken the cycle after the strobe.
// Reset is synchronous, active low, and returns the controller to idle.
`default_nettype none

module integer_calculator_lcm_gcd #(
  parameter int OPERAND_WIDTH = icl_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire icl_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output icl_pkg::out_item_t      out_item
);
  import icl_pkg::*;

  dp_ctl_t            ctl;
  dp_stat_t           stat;
  logic [VALUE_W-1:0] value;
  logic [1:0]         status;

  // Sequencer
  icl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_item.operation),
    .stat   (stat),
    .ctl    (ctl),
    .busy   (busy),
    .done   (out_valid),
    .status (status)
  );

  // Arithmetic
  icl_dpath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dpath (
    .clk   (clk),
    .ctl   (ctl),
    .in_a  (in_item.first_operand),
    .in_b  (in_item.second_operand),
    .stat  (stat),
    .value (value)
  );

  assign out_item.value  = value;
  assign out_item.status = status;

endmodule

`default_nettype wire

>>> hw/rtl/icl_checker.sv
`default_nettype none
`include "assert_macros.svh"

module icl_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire icl_pkg::out_item_t out_item
);
  import icl_pkg::*;

  logic err_out;
  logic value_zero;
  logic item_taken;

  assign err_out    = out_valid && (out_item.status != STAT_OK);
  assign value_zero = (out_item.value == '0);
  assign item_taken = start && !busy;

  // A result only appears while an item is in flight
  `ASSERT_CLKD(a_strobe_busy, clk, rst_n, out_valid |-> busy, "result strobe while idle")
  // The strobe lasts one cycle
  `ASSERT_CLKD(a_strobe_pulse, clk, rst_n, out_valid |=> !out_valid, "result strobe held")
  // A taken item makes the block busy
  `ASSERT_CLKD(a_take_busy, clk, rst_n, item_taken |=> busy, "item taken but not busy")
  // Error results carry a zero value
  `ASSERT_CLKD(a_err_zero, clk, rst_n, err_out |-> value_zero, "nonzero value with error status")
  // Reset leaves the block idle
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule

bind integer_calculator_lcm_gcd icl_checker u_icl_checker (.*);

`default_nettype wire
